FILE: design/ipbl_pkg.sv
// ----------------------------------------------------------------------------
// ipbl_pkg
// Shared types and constants of the source address and port blocklist filter.
// ----------------------------------------------------------------------------
package ipbl_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int CNT_W_DEF       = $clog2(MAX_ENTRIES_DEF + 1);

  localparam logic [3:0] IP_VERSION_4 = 4'd4;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [15:0] PORT_ANY    = 16'd0;

  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_ADD      = 2'd1,
    OP_FLUSH    = 2'd2
  } op_t;

  // Token that walks down the chain of rule cells, one cell per cycle while the chain is not held.
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic        v4;
    logic [31:0] addr;
    logic [15:0] port;
    logic        wr;
    logic        hit;
  } tok_t;

endpackage

FILE: design/ipbl_if.sv
// ----------------------------------------------------------------------------
// ipbl_if
// Request and result channels of the blocklist filter.
// ----------------------------------------------------------------------------
interface ipbl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  ip_version;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;
  logic [15:0] source_port;
  logic [31:0] new_rule_address;
  logic [15:0] new_rule_port;

  modport source (
    output valid, operation, ip_version, ip_protocol, source_address,
           source_port, new_rule_address, new_rule_port,
    input  ready
  );
  modport sink (
    input  valid, operation, ip_version, ip_protocol, source_address,
           source_port, new_rule_address, new_rule_port,
    output ready
  );
endinterface

interface ipbl_out_if #(
  parameter int CNT_W = ipbl_pkg::CNT_W_DEF
);
  logic             valid;
  logic             ready;
  logic             verdict;
  logic             status;
  logic [31:0]      accepted_total;
  logic [31:0]      dropped_total;
  logic [CNT_W-1:0] rules_in_use;

  modport source (
    output valid, verdict, status, accepted_total, dropped_total, rules_in_use,
    input  ready
  );
  modport sink (
    input  valid, verdict, status, accepted_total, dropped_total, rules_in_use,
    output ready
  );
endinterface

FILE: design/ipbl_cell.sv
// ----------------------------------------------------------------------------
// ipbl_cell
// One rule slot: stores a rule, matches passing packets, forwards the token.
// ----------------------------------------------------------------------------
module ipbl_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = ipbl_pkg::CNT_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ipbl_pkg::tok_t       tok_in,
  input  logic [CNT_W-1:0]     cnt_in,
  output ipbl_pkg::tok_t       tok_out,
  output logic [CNT_W-1:0]     cnt_out
);

  logic [31:0] rule_addr;
  logic [15:0] rule_port;
  logic        in_use;
  logic        match;
  logic        write_here;

  // The count carried by the token is the rule total after that item, so an
  // accepted add lands in the cell whose index is one below it.
  assign in_use     = cnt_in > CNT_W'(INDEX);
  assign write_here = tok_in.valid && (tok_in.op == ipbl_pkg::OP_ADD) && tok_in.wr &&
                      (cnt_in == CNT_W'(INDEX + 1));
  assign match      = tok_in.valid && (tok_in.op == ipbl_pkg::OP_CLASSIFY) && tok_in.v4 &&
                      in_use && (rule_addr == tok_in.addr) &&
                      ((rule_port == ipbl_pkg::PORT_ANY) || (rule_port == tok_in.port));

  always_ff @(posedge clk) begin
    if (en && write_here) begin
      rule_addr <= tok_in.addr;
      rule_port <= tok_in.port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out.valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_out.op   <= tok_in.op;
      tok_out.v4   <= tok_in.v4;
      tok_out.addr <= tok_in.addr;
      tok_out.port <= tok_in.port;
      tok_out.wr   <= tok_in.wr;
      tok_out.hit  <= tok_in.hit | match;
      cnt_out      <= cnt_in;
    end
  end

endmodule

FILE: design/ip_port_blocklist_filter.sv
// ----------------------------------------------------------------------------
// ip_port_blocklist_filter
// Source address and port blocklist with a systolic chain of rule cells.
// ----------------------------------------------------------------------------
// Every request item enters a chain of MAX_ENTRIES rule cells and moves one
// cell per cycle while the chain is not held, so a new item can be taken every
// cycle and its result comes out of the output stage behind the last cell, in
// order. The whole chain holds while a result waits on the output.
// Added rules are written into their cell as the add item passes it, and a
// flush only clears the rule count, so items always see the table exactly as
// the items ahead of them left it.
module ip_port_blocklist_filter #(
  parameter int MAX_ENTRIES = ipbl_pkg::MAX_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ipbl_in_if.sink       request,
  ipbl_out_if.source    result
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  ipbl_pkg::tok_t         tok [0:MAX_ENTRIES];
  logic [CNT_W-1:0]       cnt [0:MAX_ENTRIES];

  logic [CNT_W-1:0] rule_total;
  logic [CNT_W-1:0] rule_total_next;
  logic             en;
  logic             accept;
  logic             full;
  logic             has_port;
  ipbl_pkg::op_t    op_in;

  logic             out_valid;
  logic             out_verdict;
  logic             out_status;
  logic [31:0]      acc_total;
  logic [31:0]      drop_total;
  logic [CNT_W-1:0] out_rules;
  ipbl_pkg::tok_t   tail;

  // The chain advances whenever the output stage is free or being emptied.
  assign en            = !out_valid || result.ready;
  assign request.ready = en;
  assign accept        = request.valid && en;

  assign op_in    = ipbl_pkg::op_t'(request.operation);
  assign full     = rule_total >= CNT_W'(MAX_ENTRIES);
  assign has_port = (request.ip_protocol == ipbl_pkg::PROTO_TCP) ||
                    (request.ip_protocol == ipbl_pkg::PROTO_UDP);

  always_comb begin
    rule_total_next = rule_total;
    case (op_in)
      ipbl_pkg::OP_ADD:   if (!full) rule_total_next = rule_total + CNT_W'(1);
      ipbl_pkg::OP_FLUSH: rule_total_next = '0;
      default:            rule_total_next = rule_total;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_total <= '0;
    end else if (accept) begin
      rule_total <= rule_total_next;
    end
  end

  always_comb begin
    tok[0].valid = request.valid;
    tok[0].op    = op_in;
    tok[0].v4    = request.ip_version == ipbl_pkg::IP_VERSION_4;
    tok[0].wr    = !full;
    tok[0].hit   = 1'b0;
    if (op_in == ipbl_pkg::OP_CLASSIFY) begin
      tok[0].addr = request.source_address;
      tok[0].port = has_port ? request.source_port : ipbl_pkg::PORT_ANY;
    end else begin
      tok[0].addr = request.new_rule_address;
      tok[0].port = request.new_rule_port;
    end
    cnt[0] = rule_total_next;
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    ipbl_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (tok[i]),
      .cnt_in  (cnt[i]),
      .tok_out (tok[i+1]),
      .cnt_out (cnt[i+1])
    );
  end

  assign tail = tok[MAX_ENTRIES];

  // Output stage: the counters only move when an item is loaded here, so they
  // always show the totals after the item on display.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      acc_total  <= '0;
      drop_total <= '0;
    end else if (en) begin
      out_valid <= tail.valid;
      if (tail.valid && (tail.op == ipbl_pkg::OP_CLASSIFY)) begin
        if (tail.hit) begin
          drop_total <= drop_total + 32'd1;
        end else begin
          acc_total <= acc_total + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_verdict <= (tail.op == ipbl_pkg::OP_CLASSIFY) && tail.hit;
      out_status  <= (tail.op == ipbl_pkg::OP_ADD) && !tail.wr;
      out_rules   <= cnt[MAX_ENTRIES];
    end
  end

  assign result.valid          = out_valid;
  assign result.verdict        = out_verdict;
  assign result.status         = out_status;
  assign result.accepted_total = acc_total;
  assign result.dropped_total  = drop_total;
  assign result.rules_in_use   = out_rules;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    rule_total <= CNT_W'(MAX_ENTRIES))
    else $error("rule count beyond table size");

  a_verdict_status: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.verdict && result.status))
    else $error("drop verdict and refused add on one item");

  a_hold_counters: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> $stable(acc_total) && $stable(drop_total))
    else $error("counters moved while a result was stalled");

  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    accept && (op_in == ipbl_pkg::OP_ADD) && !full |=> rule_total != '0)
    else $error("accepted add left the table empty");

endmodule
